// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, with an explicit implication from a trigger to a consequence.
`define ASSERT_IMPL(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pist_pkg.sv =====
package pist_pkg;

    localparam int PAGE_W   = 31;
    localparam int TOTAL_W  = 7;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_UNUSED = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MODE_EITHER = 2'd0,
        MODE_LOWER  = 2'd1,
        MODE_UPPER  = 2'd2,
        MODE_QUIET  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_COVERED = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADPAGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_JOIN,
        OP_EXT_LOW,
        OP_EXT_UP,
        OP_NEW,
        OP_TOK_START,
        OP_TOK_STEP
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [PAGE_W-1:0]   page;
    } t_cell_cmd;

endpackage

// ===== hdl/pist_if.sv =====
interface pist_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic [pist_pkg::PAGE_W-1:0]  page_number;
    logic [1:0]                   merge_mode;

    modport source (output valid, func, page_number, merge_mode, input ready);
    modport sink   (input valid, func, page_number, merge_mode, output ready);
endinterface

interface pist_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [pist_pkg::PAGE_W-1:0]  next_page;
    logic                         merged_with_lower;
    logic                         merged_with_upper;
    logic [pist_pkg::TOTAL_W-1:0] range_total;

    modport source (output valid, status, next_page, merged_with_lower,
                    merged_with_upper, range_total, input ready);
    modport sink   (input valid, status, next_page, merged_with_lower,
                    merged_with_upper, range_total, output ready);
endinterface

// ===== hdl/pist_cell.sv =====
module pist_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pist_pkg::t_cell_cmd           i_cmd,
    input  logic                          i_valid,
    input  logic                          i_prev_le,
    input  logic [pist_pkg::PAGE_W-1:0]   i_prev_low,
    input  logic [pist_pkg::PAGE_W-1:0]   i_prev_high,
    input  logic                          i_prev_tok,
    input  logic                          i_next_le,
    input  logic [pist_pkg::PAGE_W-1:0]   i_next_low,
    input  logic [pist_pkg::PAGE_W-1:0]   i_next_high,
    input  logic                          i_next_touch,
    output logic                          o_le,
    output logic [pist_pkg::PAGE_W-1:0]   o_low,
    output logic [pist_pkg::PAGE_W-1:0]   o_high,
    output logic                          o_touch,
    output logic                          o_tok,
    output logic                          o_cur,
    output logic                          o_nxt,
    output logic                          o_cov,
    output logic                          o_adjl,
    output logic                          o_adju,
    output logic                          o_stop
);
    import pist_pkg::*;

    logic [PAGE_W-1:0] r_low, n_low;
    logic [PAGE_W-1:0] r_high, n_high;
    logic              r_tok, n_tok;
    logic [PAGE_W:0]   w_page_x, w_low_x, w_high_x;

    assign w_page_x = {1'b0, i_cmd.page};
    assign w_low_x  = {1'b0, r_low};
    assign w_high_x = {1'b0, r_high};

    // The table is sorted, so the cells whose low page is not above the
    // page form a prefix; its last member holds the lower range.
    assign o_le    = i_valid && (r_low <= i_cmd.page);
    assign o_cur   = o_le && !i_next_le;
    assign o_nxt   = i_valid && !o_le && i_prev_le;
    assign o_cov   = o_cur && (i_cmd.page <= r_high);
    assign o_adjl  = o_cur && (w_page_x == w_high_x + 1'b1);
    assign o_adju  = o_nxt && (w_page_x + 1'b1 == w_low_x);
    assign o_touch = i_valid && ({1'b0, i_prev_high} + 1'b1 == w_low_x);
    assign o_stop  = r_tok && !i_next_touch;
    assign o_low   = r_low;
    assign o_high  = r_high;
    assign o_tok   = r_tok;

    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        n_tok  = 1'b0;
        case (i_cmd.op)
            OP_JOIN: begin
                if (o_cur) begin
                    n_high = i_next_high;
                end else if (!o_le) begin
                    n_low  = i_next_low;
                    n_high = i_next_high;
                end
            end
            OP_EXT_LOW: begin
                if (o_cur) begin
                    n_high = i_cmd.page;
                end
            end
            OP_EXT_UP: begin
                if (o_nxt) begin
                    n_low = i_cmd.page;
                end
            end
            OP_NEW: begin
                if (!o_le && i_prev_le) begin
                    n_low  = i_cmd.page;
                    n_high = i_cmd.page;
                end else if (!o_le) begin
                    n_low  = i_prev_low;
                    n_high = i_prev_high;
                end
            end
            OP_TOK_START: n_tok = o_cur;
            OP_TOK_STEP:  n_tok = i_prev_tok && o_touch;
            default:      n_tok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_low  <= n_low;
        r_high <= n_high;
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

endmodule

// ===== hdl/page_interval_set_tracker.sv =====
// Page interval set tracker: holds up to MAX_RANGES disjoint page ranges, sorted by low
// page, in a row of cells (one range per cell). Each transfer on i_in carries an insert,
// a query or a clear, and gives exactly one result transfer on o_out. Items are taken one
// at a time. An insert, a clear, or a query whose page no range covers goes through the
// steps accept, compare in every cell, apply and load result. A query whose page is
// covered adds a walk between apply and load result: the walk starts in the covering cell
// and then moves a token one cell per cycle along the chain of touching ranges. A result
// that waits on o_out holds the next item in its load-result step until the result
// transfer happens. Inserting a new range or joining two shifts every cell above the
// insertion point by one place in the apply step. The next item can be accepted while
// a result still waits on o_out. No clearing pass is needed after reset: the range
// count bounds every read.
`include "assert_macros.svh"

module page_interval_set_tracker #(
    parameter int MAX_RANGES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pist_in_if.sink     i_in,
    pist_out_if.source  o_out
);
    import pist_pkg::*;

    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_WALK,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [1:0]         r_func;
    logic [PAGE_W-1:0]  r_page;
    logic [1:0]         r_mode;
    logic [CW-1:0]      r_count;
    logic               r_cov, r_adjl, r_adju;
    logic [1:0]         r_status;
    logic [PAGE_W-1:0]  r_next;
    logic               r_mlow, r_mup;

    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic [PAGE_W-1:0]  r_o_next;
    logic               r_o_mlow, r_o_mup;
    logic [TOTAL_W-1:0] r_o_total;

    t_cell_cmd          w_cmd;
    logic               w_use_low, w_use_up, w_notices;

    logic [MAX_RANGES-1:0] w_le, w_touch, w_tok, w_cur, w_nxt;
    logic [MAX_RANGES-1:0] w_cov, w_adjl, w_adju, w_stop, w_valid;
    logic [PAGE_W-1:0]     w_low  [MAX_RANGES];
    logic [PAGE_W-1:0]     w_high [MAX_RANGES];
    logic [PAGE_W-1:0]     w_answer;

    // Decision for an insert, from the flags gathered in the compare cycle.
    assign w_use_low = r_adjl && (r_mode != MODE_UPPER);
    assign w_use_up  = r_adju && (r_mode != MODE_LOWER);
    assign w_notices = (r_mode != MODE_QUIET);

    always_comb begin
        w_cmd.page = r_page;
        w_cmd.op   = OP_HOLD;
        case (r_state)
            S_APPLY: begin
                if (r_func == FUNC_INSERT && !r_cov) begin
                    if (w_use_low && w_use_up) begin
                        w_cmd.op = OP_JOIN;
                    end else if (w_use_low) begin
                        w_cmd.op = OP_EXT_LOW;
                    end else if (w_use_up) begin
                        w_cmd.op = OP_EXT_UP;
                    end else if (r_count != CW'(MAX_RANGES)) begin
                        w_cmd.op = OP_NEW;
                    end
                end else if (r_func == FUNC_QUERY && r_page != '0 && r_cov) begin
                    w_cmd.op = OP_TOK_START;
                end
            end
            S_WALK: begin
                if (w_stop == '0) begin
                    w_cmd.op = OP_TOK_STEP;
                end
            end
            default: w_cmd.op = OP_HOLD;
        endcase
    end

    // The chain of cells. Cell zero sees a virtual neighbor below whose low page is
    // always in the prefix; the top cell sees none above.
    for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
        logic              w_p_le, w_p_tok, w_n_le, w_n_touch;
        logic [PAGE_W-1:0] w_p_low, w_p_high, w_n_low, w_n_high;

        assign w_valid[i] = (CW'(i) < r_count);

        if (i == 0) begin : g_first
            assign w_p_le   = 1'b1;
            assign w_p_tok  = 1'b0;
            assign w_p_low  = '0;
            assign w_p_high = '0;
        end else begin : g_mid_lo
            assign w_p_le   = w_le[i-1];
            assign w_p_tok  = w_tok[i-1];
            assign w_p_low  = w_low[i-1];
            assign w_p_high = w_high[i-1];
        end

        if (i == MAX_RANGES - 1) begin : g_last
            assign w_n_le    = 1'b0;
            assign w_n_touch = 1'b0;
            assign w_n_low   = '0;
            assign w_n_high  = '0;
        end else begin : g_mid_hi
            assign w_n_le    = w_le[i+1];
            assign w_n_touch = w_touch[i+1];
            assign w_n_low   = w_low[i+1];
            assign w_n_high  = w_high[i+1];
        end

        pist_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_valid      (w_valid[i]),
            .i_prev_le    (w_p_le),
            .i_prev_low   (w_p_low),
            .i_prev_high  (w_p_high),
            .i_prev_tok   (w_p_tok),
            .i_next_le    (w_n_le),
            .i_next_low   (w_n_low),
            .i_next_high  (w_n_high),
            .i_next_touch (w_n_touch),
            .o_le         (w_le[i]),
            .o_low        (w_low[i]),
            .o_high       (w_high[i]),
            .o_touch      (w_touch[i]),
            .o_tok        (w_tok[i]),
            .o_cur        (w_cur[i]),
            .o_nxt        (w_nxt[i]),
            .o_cov        (w_cov[i]),
            .o_adjl       (w_adjl[i]),
            .o_adju       (w_adju[i]),
            .o_stop       (w_stop[i])
        );
    end

    // The walk ends at the single cell holding the token with no touching range above;
    // the answer is the page after its high end, wrapping to zero past the top page.
    always_comb begin
        w_answer = '0;
        for (int k = 0; k < MAX_RANGES; k++) begin
            if (w_stop[k]) begin
                w_answer = w_answer | (w_high[k] + 1'b1);
            end
        end
    end

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = r_o_valid;
    assign o_out.status            = r_o_status;
    assign o_out.next_page         = r_o_next;
    assign o_out.merged_with_lower = r_o_mlow;
    assign o_out.merged_with_upper = r_o_mup;
    assign o_out.range_total       = r_o_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // In S_DONE the result register is reloaded below instead.
            if (o_out.ready && r_o_valid && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func   <= i_in.func;
                        r_page   <= i_in.page_number;
                        r_mode   <= i_in.merge_mode;
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_cov    <= |w_cov;
                    r_adjl   <= |w_adjl;
                    r_adju   <= |w_adju;
                    r_status <= ST_OK;
                    r_next   <= '0;
                    r_mlow   <= 1'b0;
                    r_mup    <= 1'b0;
                    r_state  <= S_APPLY;
                end
                S_APPLY: begin
                    r_state <= S_DONE;
                    case (r_func)
                        FUNC_INSERT: begin
                            if (r_cov) begin
                                r_status <= ST_COVERED;
                            end else if (w_use_low || w_use_up) begin
                                r_mlow <= w_use_low && w_notices;
                                r_mup  <= w_use_up && w_notices;
                                if (w_use_low && w_use_up) begin
                                    r_count <= r_count - 1'b1;
                                end
                            end else if (r_count == CW'(MAX_RANGES)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        FUNC_QUERY: begin
                            if (r_page == '0) begin
                                r_status <= ST_BADPAGE;
                            end else if (!r_cov) begin
                                r_next <= r_page;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end
                        FUNC_CLEAR: r_count <= '0;
                        default:    r_status <= ST_OK;
                    endcase
                end
                S_WALK: begin
                    if (w_stop != '0) begin
                        r_next  <= w_answer;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_next   <= r_next;
                        r_o_mlow   <= r_mlow;
                        r_o_mup    <= r_mup;
                        r_o_total  <= TOTAL_W'(r_count);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_RANGES), "count over capacity")
    `ASSERT_CLK(a_tok_single, i_clk, i_rst_n, $onehot0(w_tok), "more than one walk token")
    `ASSERT_IMPL(a_walk_tok, i_clk, i_rst_n, r_state == S_WALK, $onehot(w_tok), "no walk token")
    `ASSERT_IMPL(a_cur_single, i_clk, i_rst_n, r_state == S_EVAL, $onehot0(w_cur), "multiple cur")
    `ASSERT_IMPL(a_nxt_single, i_clk, i_rst_n, r_state == S_EVAL, $onehot0(w_nxt), "multiple nxt")

endmodule
